[design/pkvt_pkg.sv]
// Package for the pair keyed value table.
// Holds default sizes, field widths and operation codes; depends on nothing.
package pkvt_pkg;

    localparam int CAPACITY    = 256;
    localparam int SYMBOL_BITS = 24;
    localparam int HANDLE_BITS = 20;
    localparam int COUNT_BITS  = 9;
    localparam int OP_BITS     = 2;

    localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SET    = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

endpackage

[design/pair_keyed_value_table.sv]
// Pair keyed value table: lookup, set and delete on keys made of two symbol identifiers.
// Depends on pkvt_pkg and pkvt_entry_ram.
// Each scanned entry is read (S_ISSUE), then compared (S_CHECK); a moving delete adds S_MOVE.
// Throughput: one request at a time; busy is high from acceptance until the result strobe.
// Entries are kept packed below the fill count; one compare unit checks one entry per scan step.
// Reset (synchronous, active low) empties the table at once; the result cannot be stalled.
module pair_keyed_value_table #(
    parameter int CAPACITY    = pkvt_pkg::CAPACITY,
    parameter int SYMBOL_BITS = pkvt_pkg::SYMBOL_BITS,
    parameter int HANDLE_BITS = pkvt_pkg::HANDLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pkvt_pkg::OP_BITS-1:0] i_operation,
    input  logic [SYMBOL_BITS-1:0]       i_first_symbol,
    input  logic [SYMBOL_BITS-1:0]       i_second_symbol,
    input  logic [HANDLE_BITS-1:0]       i_handle_in,
    output logic                         o_result_valid,
    output logic                         o_was_present,
    output logic [HANDLE_BITS-1:0]       o_handle_out,
    output logic [pkvt_pkg::COUNT_BITS-1:0] o_entry_count,
    output logic                         o_status
);

    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int CMP_BITS  = ADDR_BITS + 1;
    localparam int KEY_BITS  = 2 * SYMBOL_BITS;
    localparam int ENT_BITS  = KEY_BITS + HANDLE_BITS;
    localparam int CB        = pkvt_pkg::COUNT_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_ACT   = 3'd3;
    localparam logic [2:0] S_MOVE  = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [pkvt_pkg::OP_BITS-1:0] r_op, n_op;
    logic [SYMBOL_BITS-1:0]      r_a, n_a, r_b, n_b;
    logic [HANDLE_BITS-1:0]      r_h, n_h;
    logic [ADDR_BITS-1:0]        r_addr, n_addr;
    logic [ADDR_BITS-1:0]        r_slot, n_slot;
    logic                        r_found, n_found;
    logic [HANDLE_BITS-1:0]      r_old, n_old;
    logic [CNT_BITS-1:0]         r_count, n_count;
    logic                        r_res_valid, n_res_valid;
    logic                        r_was, n_was;
    logic [HANDLE_BITS-1:0]      r_hout, n_hout;
    logic                        r_status, n_status;

    logic                        rd_en, wr_en;
    logic [ADDR_BITS-1:0]        rd_addr, wr_addr;
    logic [ENT_BITS-1:0]         wr_data, rd_data;
    logic [KEY_BITS-1:0]         rd_key;
    logic [HANDLE_BITS-1:0]      rd_hnd;
    logic [CMP_BITS-1:0]         addr_nx, count_x;
    logic [CNT_BITS-1:0]         cnt_m1;
    logic [ADDR_BITS-1:0]        last_addr, fill_addr;
    logic                        full;
    logic [CNT_BITS+CB-1:0]      count_ext;

    pkvt_entry_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_key    = rd_data[ENT_BITS-1:HANDLE_BITS];
    assign rd_hnd    = rd_data[HANDLE_BITS-1:0];
    assign addr_nx   = CMP_BITS'(r_addr) + CMP_BITS'(1);
    assign count_x   = CMP_BITS'(r_count);
    assign cnt_m1    = r_count - CNT_BITS'(1);
    assign last_addr = cnt_m1[ADDR_BITS-1:0];
    assign fill_addr = r_count[ADDR_BITS-1:0];
    assign full      = (r_count == CNT_BITS'(CAPACITY));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_h         = r_h;
        n_addr      = r_addr;
        n_slot      = r_slot;
        n_found     = r_found;
        n_old       = r_old;
        n_count     = r_count;
        n_res_valid = 1'b0;
        n_was       = r_was;
        n_hout      = r_hout;
        n_status    = r_status;
        rd_en       = 1'b0;
        rd_addr     = r_addr;
        wr_en       = 1'b0;
        wr_addr     = r_slot;
        wr_data     = {r_a, r_b, r_h};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_a     = i_first_symbol;
                    n_b     = i_second_symbol;
                    n_h     = i_handle_in;
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_old   = '0;
                    n_state = (r_count == '0) ? S_ACT : S_ISSUE;
                end
            end
            S_ISSUE: begin
                rd_en   = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (rd_key == {r_a, r_b}) begin
                    n_found = 1'b1;
                    n_slot  = r_addr;
                    n_old   = rd_hnd;
                    n_state = S_ACT;
                end else if (addr_nx == count_x) begin
                    n_state = S_ACT;
                end else begin
                    n_addr  = addr_nx[ADDR_BITS-1:0];
                    n_state = S_ISSUE;
                end
            end
            S_ACT: begin
                n_res_valid = 1'b1;
                n_was       = r_found;
                n_hout      = r_old;
                n_status    = 1'b0;
                n_state     = S_IDLE;
                case (r_op)
                    pkvt_pkg::OP_SET: begin
                        if (r_found) begin
                            wr_en = 1'b1;
                        end else if (!full) begin
                            wr_en   = 1'b1;
                            wr_addr = fill_addr;
                            n_count = r_count + CNT_BITS'(1);
                        end else begin
                            n_status = 1'b1;
                        end
                    end
                    pkvt_pkg::OP_DELETE: begin
                        if (r_found && (r_h == '0 || r_old == r_h)) begin
                            if (r_slot == last_addr) begin
                                n_count = cnt_m1;
                            end else begin
                                // fetch the last entry to fill the gap
                                rd_en       = 1'b1;
                                rd_addr     = last_addr;
                                n_res_valid = 1'b0;
                                n_state     = S_MOVE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MOVE: begin
                wr_en       = 1'b1;
                wr_data     = rd_data;
                n_count     = cnt_m1;
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_h      <= n_h;
        r_addr   <= n_addr;
        r_slot   <= n_slot;
        r_found  <= n_found;
        r_old    <= n_old;
        r_was    <= n_was;
        r_hout   <= n_hout;
        r_status <= n_status;
    end

    assign count_ext      = {{CB{1'b0}}, r_count};
    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_was_present  = r_was;
    assign o_handle_out   = r_hout;
    assign o_entry_count  = count_ext[CB-1:0];
    assign o_status       = r_status;

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !busy)
        else $error("result strobe while busy");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("fill count beyond capacity");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_status) |-> full)
        else $error("insert dropped with room left");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_was) |-> (r_hout == '0))
        else $error("absent key reported a handle");

endmodule

[design/pkvt_entry_ram.sv]
// Entry store of the pair keyed value table: one write port, one registered read port.
// Standalone; sizes come from the parameters handed down by the top level.
module pkvt_entry_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 68,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[test/pair_keyed_value_table_tb.sv]
// Testbench for pair_keyed_value_table: directed and random lookup, set and delete requests,
// each checked against a table kept alongside in a scoreboard class.
// Depends on pkvt_pkg and the pair_keyed_value_table RTL.
module pair_keyed_value_table_tb;

    localparam int CAPACITY    = pkvt_pkg::CAPACITY;
    localparam int SYMBOL_BITS = pkvt_pkg::SYMBOL_BITS;
    localparam int HANDLE_BITS = pkvt_pkg::HANDLE_BITS;
    localparam int COUNT_BITS  = pkvt_pkg::COUNT_BITS;
    localparam int OP_BITS     = pkvt_pkg::OP_BITS;
    localparam int KEY_BITS    = 2 * SYMBOL_BITS;
    localparam int POOL_SIZE   = 40;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                   was_present;
        logic [HANDLE_BITS-1:0] handle;
        logic [COUNT_BITS-1:0]  count;
        logic                   status;
    } t_table_result;

    class t_table_scoreboard;
        logic [HANDLE_BITS-1:0] handle_by_key [bit [KEY_BITS-1:0]];
        bit [KEY_BITS-1:0]      held_keys[$];
        t_table_result          due_results[$];
        int                     errors = 0;

        function void note_request(logic [OP_BITS-1:0] op, logic [SYMBOL_BITS-1:0] first,
                                   logic [SYMBOL_BITS-1:0] second,
                                   logic [HANDLE_BITS-1:0] handle);
            bit [KEY_BITS-1:0] key;
            t_table_result     res;
            key = {first, second};
            res.was_present = handle_by_key.exists(key);
            res.handle = res.was_present ? handle_by_key[key] : '0;
            res.status = 1'b0;
            case (op)
                pkvt_pkg::OP_SET: begin
                    if (res.was_present) begin
                        handle_by_key[key] = handle;
                    end else if (handle_by_key.num() < CAPACITY) begin
                        handle_by_key[key] = handle;
                        held_keys.push_back(key);
                    end else begin
                        res.status = 1'b1;
                    end
                end
                pkvt_pkg::OP_DELETE: begin
                    if (res.was_present && (handle == '0 || handle == res.handle)) begin
                        handle_by_key.delete(key);
                        for (int i = 0; i < held_keys.size(); i++) begin
                            if (held_keys[i] == key) begin
                                held_keys.delete(i);
                                break;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            res.count = COUNT_BITS'(handle_by_key.num());
            due_results.push_back(res);
        endfunction

        function void check_result(logic was_present, logic [HANDLE_BITS-1:0] handle,
                                   logic [COUNT_BITS-1:0] count, logic status);
            t_table_result want;
            if (due_results.size() == 0) begin
                $error("result strobe with no request outstanding");
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (was_present !== want.was_present) begin
                $error("was_present: expected %0d, got %0d", want.was_present, was_present);
                errors++;
            end
            if (handle !== want.handle) begin
                $error("handle_out: expected %h, got %h", want.handle, handle);
                errors++;
            end
            if (count !== want.count) begin
                $error("entry_count: expected %0d, got %0d", want.count, count);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [OP_BITS-1:0]     i_operation = pkvt_pkg::OP_LOOKUP;
    logic [SYMBOL_BITS-1:0] i_first_symbol = '0;
    logic [SYMBOL_BITS-1:0] i_second_symbol = '0;
    logic [HANDLE_BITS-1:0] i_handle_in = '0;
    logic                   o_result_valid;
    logic                   o_was_present;
    logic [HANDLE_BITS-1:0] o_handle_out;
    logic [COUNT_BITS-1:0]  o_entry_count;
    logic                   o_status;

    t_table_scoreboard sb = new;
    bit [KEY_BITS-1:0] key_pool [POOL_SIZE];
    bit                no_idle = 1'b0;
    int                sent = 0;
    int                r_cycles = 0;

    pair_keyed_value_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_first_symbol  (i_first_symbol),
        .i_second_symbol (i_second_symbol),
        .i_handle_in     (i_handle_in),
        .o_result_valid  (o_result_valid),
        .o_was_present   (o_was_present),
        .o_handle_out    (o_handle_out),
        .o_entry_count   (o_entry_count),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            sb.check_result(o_was_present, o_handle_out, o_entry_count, o_status);
        end
    end

    always @(posedge i_clk) begin
        r_cycles <= r_cycles + 1;
        if (r_cycles == CYCLE_LIMIT) begin
            $display("pair_keyed_value_table_tb NOT OK");
            $finish;
        end
    end

    function automatic bit [KEY_BITS-1:0] fresh_key();
        return {SYMBOL_BITS'($urandom), SYMBOL_BITS'($urandom)};
    endfunction

    function automatic bit [KEY_BITS-1:0] held_key();
        return sb.held_keys[$urandom_range(0, sb.held_keys.size() - 1)];
    endfunction

    function automatic logic [HANDLE_BITS-1:0] wrong_handle(bit [KEY_BITS-1:0] key);
        logic [HANDLE_BITS-1:0] h;
        h = sb.handle_by_key[key] + 1'b1;
        if (h == '0) begin
            h = HANDLE_BITS'(1);
        end
        return h;
    endfunction

    task automatic send_request(input logic [OP_BITS-1:0] op, input bit [KEY_BITS-1:0] key,
                                input logic [HANDLE_BITS-1:0] handle);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation     <= op;
        i_first_symbol  <= key[KEY_BITS-1:SYMBOL_BITS];
        i_second_symbol <= key[SYMBOL_BITS-1:0];
        i_handle_in     <= handle;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(op, key[KEY_BITS-1:SYMBOL_BITS], key[SYMBOL_BITS-1:0], handle);
        sent++;
        if (sent % 48 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.due_results.size() != 0);
    endtask

    task automatic mixed_request();
        bit [KEY_BITS-1:0]      key;
        logic [OP_BITS-1:0]     op;
        logic [HANDLE_BITS-1:0] h;
        int                     r;
        key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : fresh_key();
        r = $urandom_range(0, 99);
        op = (r < 30) ? pkvt_pkg::OP_LOOKUP : (r < 60) ? pkvt_pkg::OP_SET :
             (r < 92) ? pkvt_pkg::OP_DELETE : OP_UNUSED;
        h = HANDLE_BITS'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            h = '0;
        end
        if (op == pkvt_pkg::OP_DELETE && sb.handle_by_key.exists(key)) begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
                h = '0;
            end else if (r == 1) begin
                h = sb.handle_by_key[key];
            end
        end
        send_request(op, key, h);
        if ($urandom_range(0, 39) == 0) begin
            hold_until_drained();
        end
    endtask

    localparam bit [SYMBOL_BITS-1:0] SYM_MAX = '1;
    localparam bit [KEY_BITS-1:0] KEY_ZERO = '0;
    localparam bit [KEY_BITS-1:0] KEY_MAX  = '1;
    localparam bit [KEY_BITS-1:0] KEY_HI   = {SYM_MAX, {SYMBOL_BITS{1'b0}}};
    localparam bit [KEY_BITS-1:0] KEY_LO   = {{SYMBOL_BITS{1'b0}}, SYM_MAX};

    initial begin
        bit [SYMBOL_BITS-1:0]   firsts [8];
        bit [KEY_BITS-1:0]      key;
        logic [HANDLE_BITS-1:0] h;
        int                     r;

        foreach (firsts[i]) firsts[i] = SYMBOL_BITS'($urandom);
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < 32) begin
                key_pool[i] = {firsts[i % 8], SYMBOL_BITS'($urandom)};
            end else begin
                key_pool[i] = {SYMBOL_BITS'($urandom), key_pool[i - 32][SYMBOL_BITS-1:0]};
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(pkvt_pkg::OP_LOOKUP, KEY_ZERO, '0);
        send_request(pkvt_pkg::OP_DELETE, KEY_ZERO, '0);
        send_request(pkvt_pkg::OP_SET, KEY_ZERO, '0);
        send_request(pkvt_pkg::OP_LOOKUP, KEY_ZERO, '1);
        send_request(pkvt_pkg::OP_SET, KEY_MAX, '1);
        send_request(pkvt_pkg::OP_LOOKUP, KEY_MAX, '0);
        send_request(pkvt_pkg::OP_SET, KEY_HI, 20'h5A5A5);
        send_request(pkvt_pkg::OP_SET, KEY_LO, 20'hA5A5A);
        send_request(pkvt_pkg::OP_LOOKUP, KEY_HI, '0);
        send_request(pkvt_pkg::OP_SET, KEY_MAX, 20'h12345);
        send_request(pkvt_pkg::OP_DELETE, KEY_MAX, '1);
        send_request(pkvt_pkg::OP_DELETE, KEY_MAX, 20'h12345);
        send_request(pkvt_pkg::OP_LOOKUP, KEY_MAX, '0);
        send_request(OP_UNUSED, KEY_LO, 20'h00001);
        send_request(OP_UNUSED, KEY_MAX, '1);
        send_request(pkvt_pkg::OP_DELETE, KEY_ZERO, '0);
        send_request(pkvt_pkg::OP_DELETE, KEY_HI, '0);
        send_request(pkvt_pkg::OP_DELETE, KEY_LO, 20'hA5A5A);
        hold_until_drained();

        repeat (400) mixed_request();

        // fill to capacity, then work on a full table
        while (sb.handle_by_key.num() < CAPACITY) begin
            send_request(pkvt_pkg::OP_SET, fresh_key(), HANDLE_BITS'($urandom));
        end
        hold_until_drained();
        repeat (40) begin
            r = $urandom_range(0, 6);
            case (r)
                0: send_request(pkvt_pkg::OP_SET, fresh_key(), HANDLE_BITS'($urandom));
                1: send_request(pkvt_pkg::OP_SET, held_key(),
                                ($urandom_range(0, 4) == 0) ? '0 : HANDLE_BITS'($urandom));
                2: send_request(pkvt_pkg::OP_LOOKUP, held_key(), HANDLE_BITS'($urandom));
                3: send_request(pkvt_pkg::OP_LOOKUP, fresh_key(), HANDLE_BITS'($urandom));
                4: begin
                    key = held_key();
                    send_request(pkvt_pkg::OP_DELETE, key, wrong_handle(key));
                end
                5: send_request(OP_UNUSED, held_key(), HANDLE_BITS'($urandom));
                default: begin
                    send_request(pkvt_pkg::OP_DELETE, held_key(), '0);
                    send_request(pkvt_pkg::OP_SET, fresh_key(), HANDLE_BITS'($urandom));
                    send_request(pkvt_pkg::OP_SET, fresh_key(), HANDLE_BITS'($urandom));
                end
            endcase
        end

        // drain the table
        while (sb.handle_by_key.num() > 0) begin
            r = $urandom_range(0, 19);
            key = held_key();
            if (r < 2) begin
                send_request(pkvt_pkg::OP_LOOKUP, (r == 0) ? key : fresh_key(),
                             HANDLE_BITS'($urandom));
            end else begin
                h = (r < 5) ? wrong_handle(key) : (r < 11) ? '0 : sb.handle_by_key[key];
                send_request(pkvt_pkg::OP_DELETE, key, h);
            end
        end
        hold_until_drained();

        repeat (150) mixed_request();

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("pair_keyed_value_table_tb OK");
        end else begin
            $display("pair_keyed_value_table_tb NOT OK");
        end
        $finish;
    end

endmodule

[pair_keyed_value_table.f]
design/pkvt_pkg.sv
design/pkvt_entry_ram.sv
design/pair_keyed_value_table.sv
test/pair_keyed_value_table_tb.sv
